/* rtl/bfsp_pkg.sv */
package bfsp_pkg;

	// fixed field widths of the stream and configuration ports
	localparam int NODE_BITS     = 4;
	localparam int COST_BITS     = 16;
	localparam int DIST_OUT_BITS = 24;
	localparam int S_TDATA_W     = 32;
	localparam int M_TDATA_W     = 32;
	localparam int M_PAD_W       = M_TDATA_W - DIST_OUT_BITS - 2;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 5;

	// parameter defaults
	localparam int DEF_MAX_NODES   = 16;
	localparam int DEF_MAX_EDGES   = 32;
	localparam int DEF_WEIGHT_BITS = 16;
	localparam int DEF_DIST_BITS   = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd1;

	// input kinds carried on tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_SOLVE = 1'b1;

	// datapath action selected by a control word
	typedef enum logic [2:0] {
		ACT_WAIT,
		ACT_INIT,
		ACT_FETCH,
		ACT_READ,
		ACT_RELAX,
		ACT_TREAD,
		ACT_REPORT,
		ACT_NOP
	} act_t;

	// jump condition of a control word
	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NOT_SOLVE,
		C_NO_WORK,
		C_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [2:0] upc_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// step addresses
	localparam upc_t UPC_WAIT  = 3'd0;
	localparam upc_t UPC_INIT  = 3'd1;
	localparam upc_t UPC_FETCH = 3'd2;
	localparam upc_t UPC_READ  = 3'd3;
	localparam upc_t UPC_RELAX = 3'd4;
	localparam upc_t UPC_TREAD = 3'd5;
	localparam upc_t UPC_RPT   = 3'd6;
	localparam upc_t UPC_BACK  = 3'd7;

	// control program: jump to target when the condition holds, else next step
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		case (pc)
			UPC_WAIT:  w = '{act: ACT_WAIT,   cond: C_NOT_SOLVE, target: UPC_WAIT};
			UPC_INIT:  w = '{act: ACT_INIT,   cond: C_NO_WORK,   target: UPC_TREAD};
			UPC_FETCH: w = '{act: ACT_FETCH,  cond: C_NONE,      target: UPC_WAIT};
			UPC_READ:  w = '{act: ACT_READ,   cond: C_NONE,      target: UPC_WAIT};
			UPC_RELAX: w = '{act: ACT_RELAX,  cond: C_MORE,      target: UPC_FETCH};
			UPC_TREAD: w = '{act: ACT_TREAD,  cond: C_NONE,      target: UPC_WAIT};
			UPC_RPT:   w = '{act: ACT_REPORT, cond: C_OUT_BUSY,  target: UPC_RPT};
			UPC_BACK:  w = '{act: ACT_NOP,    cond: C_ALWAYS,    target: UPC_WAIT};
			default:   w = '{act: ACT_NOP,    cond: C_ALWAYS,    target: UPC_WAIT};
		endcase
		return w;
	endfunction

endpackage

/* rtl/bellman_ford_shortest_path.sv */
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready   tuser: func; tdata: edge_from, edge_to, edge_cost, target_node
// m_*       out  m_tvalid/m_tready   tuser: is_load_ack; tdata: distance, reached, load_dropped
// cfg_*     in   cfg_we              cfg_idx selects register, cfg_wdata is the value
//
// a load transaction is answered through the output register
// a solve relaxes every loaded edge in each of nodes - 1 passes, nodes being node_count held to
// 1..MAX_NODES; each relaxation runs fetch, node read and update over the edge and distance
// memories
// a solve holds s_tready low; a finished answer waits in the output register for m_tready
// reset clears the edge count, the reached bits and the sequencer, registers to their defaults
module bellman_ford_shortest_path #(
	parameter int MAX_NODES   = bfsp_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES   = bfsp_pkg::DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = bfsp_pkg::DEF_WEIGHT_BITS,
	parameter int DIST_BITS   = bfsp_pkg::DEF_DIST_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// edge_from, edge_to, edge_cost, target_node, zero pad
	input  logic [bfsp_pkg::S_TDATA_W-1:0]   s_tdata,
	// func
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// distance, reached, load_dropped, zero pad
	output logic [bfsp_pkg::M_TDATA_W-1:0]   m_tdata,
	// is_load_ack
	output logic                             m_tuser,
	input  logic                             cfg_we,
	input  logic [bfsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bfsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import bfsp_pkg::*;

	localparam int NIW = $clog2(MAX_NODES);
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int KW  = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam int SW  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	// input fields
	logic                   in_func;
	logic [NODE_BITS-1:0]   in_from;
	logic [NODE_BITS-1:0]   in_to;
	logic [COST_BITS-1:0]   in_cost;
	logic [NODE_BITS-1:0]   in_target;

	assign in_func   = s_tuser;
	assign in_from   = s_tdata[NODE_BITS-1:0];
	assign in_to     = s_tdata[2*NODE_BITS-1:NODE_BITS];
	assign in_cost   = s_tdata[2*NODE_BITS+COST_BITS-1:2*NODE_BITS];
	assign in_target = s_tdata[3*NODE_BITS+COST_BITS-1:2*NODE_BITS+COST_BITS];

	// control and configuration state
	upc_t                    upc_q;
	logic [NODE_BITS-1:0]    src_q;
	logic [CFG_DATA_W-1:0]   ncount_q;
	logic [LW-1:0]           edges_loaded_q;
	logic [EIW-1:0]          e_q;
	logic [CW-1:0]           pass_q;
	logic [MAX_NODES-1:0]    seen_q;
	logic                    m_valid_q;

	// payload registers and memories
	logic [NODE_BITS-1:0]    origin_mem [MAX_EDGES];
	logic [NODE_BITS-1:0]    dest_mem   [MAX_EDGES];
	logic [WEIGHT_BITS-1:0]  weight_mem [MAX_EDGES];
	logic [DIST_BITS-1:0]    dist_mem   [MAX_NODES];
	logic [NODE_BITS-1:0]    eo_q;
	logic [NODE_BITS-1:0]    ed_q;
	logic [WEIGHT_BITS-1:0]  ew_q;
	logic [DIST_BITS-1:0]    da_q;
	logic [DIST_BITS-1:0]    db_q;
	logic [NODE_BITS-1:0]    target_q;
	logic [M_TDATA_W-1:0]    m_data_q;
	logic                    m_user_q;

	uword_t uw;
	assign uw = ucode_rom(upc_q);

	// nodes in use, clamped to one and to capacity
	logic [KW-1:0] nodes_k;
	always_comb begin
		if (ncount_q == '0) begin
			nodes_k = KW'(1);
		end else if (KW'(ncount_q) > KW'(MAX_NODES)) begin
			nodes_k = KW'(MAX_NODES);
		end else begin
			nodes_k = KW'(ncount_q);
		end
	end

	// handshake
	logic out_free, s_acc, table_full;
	assign out_free   = !m_valid_q || m_tready;
	assign s_tready   = (uw.act == ACT_WAIT) && out_free;
	assign s_acc      = s_tvalid && s_tready;
	assign table_full = (edges_loaded_q == LW'(MAX_EDGES));

	// relaxation of the fetched edge
	logic                  a_in, b_in, src_in, tgt_hit, edge_ok, upd;
	logic [SW-1:0]         sum;
	logic [DIST_BITS-1:0]  sum_sat;
	assign a_in    = KW'(eo_q) < nodes_k;
	assign b_in    = KW'(ed_q) < nodes_k;
	assign src_in  = KW'(src_q) < nodes_k;
	assign tgt_hit = (KW'(target_q) < nodes_k) && seen_q[NIW'(target_q)];
	assign edge_ok = a_in && b_in && seen_q[NIW'(eo_q)];
	assign sum     = SW'(da_q) + SW'(ew_q);
	assign sum_sat = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);
	assign upd     = edge_ok && (!seen_q[NIW'(ed_q)] || sum_sat < db_q);

	// end of the edge list and of the passes
	logic last_edge, last_pass, no_work;
	assign last_edge = (LW'(e_q) + LW'(1)) == edges_loaded_q;
	assign last_pass = KW'(pass_q) == (nodes_k - KW'(2));
	assign no_work   = (nodes_k == KW'(1)) || (edges_loaded_q == '0);

	// jump condition
	logic cond_hit;
	always_comb begin
		case (uw.cond)
			C_NONE:      cond_hit = 1'b0;
			C_ALWAYS:    cond_hit = 1'b1;
			C_NOT_SOLVE: cond_hit = !(s_acc && in_func == FUNC_SOLVE);
			C_NO_WORK:   cond_hit = no_work;
			C_MORE:      cond_hit = !(last_edge && last_pass);
			C_OUT_BUSY:  cond_hit = !out_free;
			default:     cond_hit = 1'b1;
		endcase
	end

	// distance memory write port
	logic                  dist_we;
	logic [NIW-1:0]        dist_wa;
	logic [DIST_BITS-1:0]  dist_wd;
	always_comb begin
		dist_we = 1'b0;
		dist_wa = NIW'(ed_q);
		dist_wd = sum_sat;
		if (uw.act == ACT_INIT) begin
			dist_we = src_in;
			dist_wa = NIW'(src_q);
			dist_wd = '0;
		end else if (uw.act == ACT_RELAX) begin
			dist_we = upd;
		end
	end

	// sequencer, counters, reached bits, output valid, registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q          <= UPC_WAIT;
			src_q          <= '0;
			ncount_q       <= CFG_DATA_W'(16);
			edges_loaded_q <= '0;
			e_q            <= '0;
			pass_q         <= '0;
			seen_q         <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			upc_q <= cond_hit ? uw.target : upc_t'(upc_q + 3'd1);
			if (cfg_we) begin
				case (cfg_idx)
					REG_SOURCE_NODE: src_q    <= cfg_wdata[NODE_BITS-1:0];
					REG_NODE_COUNT:  ncount_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (uw.act)
				ACT_WAIT: begin
					if (s_acc) begin
						if (in_func == FUNC_LOAD) begin
							m_valid_q <= 1'b1;
							if (!table_full) begin
								edges_loaded_q <= edges_loaded_q + LW'(1);
							end
						end
					end
				end
				ACT_INIT: begin
					e_q    <= '0;
					pass_q <= '0;
					seen_q <= '0;
					if (src_in) begin
						seen_q[NIW'(src_q)] <= 1'b1;
					end
				end
				ACT_RELAX: begin
					if (upd) begin
						seen_q[NIW'(ed_q)] <= 1'b1;
					end
					if (last_edge) begin
						e_q    <= '0;
						pass_q <= pass_q + CW'(1);
					end else begin
						e_q <= e_q + EIW'(1);
					end
				end
				ACT_REPORT: begin
					if (out_free) begin
						m_valid_q      <= 1'b1;
						edges_loaded_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// edge table, node distances and result payload
	always_ff @(posedge clk) begin
		if (uw.act == ACT_WAIT && s_acc) begin
			target_q <= in_target;
			if (in_func == FUNC_LOAD) begin
				m_data_q <= {M_PAD_W'(0), !table_full ? 1'b0 : 1'b1, 1'b0,
					DIST_OUT_BITS'(0)};
				m_user_q <= 1'b1;
				if (!table_full) begin
					origin_mem[EIW'(edges_loaded_q)] <= in_from;
					dest_mem[EIW'(edges_loaded_q)]   <= in_to;
					weight_mem[EIW'(edges_loaded_q)] <= WEIGHT_BITS'(in_cost);
				end
			end
		end
		if (uw.act == ACT_FETCH) begin
			eo_q <= origin_mem[e_q];
			ed_q <= dest_mem[e_q];
			ew_q <= weight_mem[e_q];
		end
		if (uw.act == ACT_READ) begin
			da_q <= dist_mem[NIW'(eo_q)];
			db_q <= dist_mem[NIW'(ed_q)];
		end
		if (uw.act == ACT_TREAD) begin
			da_q <= dist_mem[NIW'(target_q)];
		end
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		if (uw.act == ACT_REPORT && out_free) begin
			m_data_q <= {M_PAD_W'(0), 1'b0, tgt_hit,
				tgt_hit ? DIST_OUT_BITS'(da_q) : DIST_OUT_BITS'(0)};
			m_user_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// edge count stays within capacity
	a_edges_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edges_loaded_q <= LW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	// a fetched edge lies inside the loaded part of the table
	a_fetch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_FETCH) |-> (LW'(e_q) < edges_loaded_q))
		else $error("edge fetch past loaded edges");

	// an accepted solve starts the init step
	a_solve_init: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && in_func == FUNC_SOLVE) |=> (upc_q == UPC_INIT))
		else $error("solve did not enter init");

	// a solve answer placed in the output register empties the edge table
	a_report_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.act == ACT_REPORT && out_free) |=> (edges_loaded_q == '0) && m_valid_q)
		else $error("report did not clear edge table");

endmodule

/* tb/sv/bellman_ford_shortest_path_tb.sv */
module bellman_ford_shortest_path_tb;
	import bfsp_pkg::*;

	localparam int EDGE_SLOTS   = DEF_MAX_EDGES;
	localparam int NODE_SLOTS   = DEF_MAX_NODES;
	localparam int RANDOM_ITEMS = 1170;
	localparam int QUIET_TAIL   = 1000;
	localparam int IDLE_LIMIT   = 20000;
	localparam int SETTLE       = 4;
	localparam int DIR_ROWS     = 18;
	localparam logic [DIST_OUT_BITS-1:0] DIST_TOP = '1;

	typedef struct packed {
		logic                 func;
		logic [NODE_BITS-1:0] org;
		logic [NODE_BITS-1:0] dst;
		logic [COST_BITS-1:0] cost;
		logic [NODE_BITS-1:0] tgt;
	} edge_req_t;

	typedef struct packed {
		logic [DIST_OUT_BITS-1:0] distance;
		logic                     reached;
		logic                     dropped;
		logic                     load_ack;
	} answer_t;

	typedef struct packed {
		edge_req_t req;
		logic      typed;
		answer_t   want;
	} dir_row_t;

	localparam answer_t ANS_ACK  = '{24'd0, 1'b0, 1'b0, 1'b1};
	localparam answer_t ANS_MISS = '{24'd0, 1'b0, 1'b0, 1'b0};
	localparam answer_t ANS_SRC  = '{24'd0, 1'b1, 1'b0, 1'b0};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// edge_from, edge_to, edge_cost, target_node, zero pad
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	// func
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// distance, reached, load_dropped, zero pad
	logic [M_TDATA_W-1:0]  m_tdata;
	// is_load_ack
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	bellman_ford_shortest_path u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the edge table and the registers
	logic [NODE_BITS-1:0] tbl_org  [EDGE_SLOTS];
	logic [NODE_BITS-1:0] tbl_dst  [EDGE_SLOTS];
	logic [COST_BITS-1:0] tbl_cost [EDGE_SLOTS];
	int                   tbl_len = 0;
	logic [NODE_BITS-1:0] cur_source = 4'd0;
	logic [4:0]           cur_count = 5'd16;

	answer_t pending_answers [$];
	int      mismatches = 0;
	int      sent_items = 0;
	int      idle_cycles = 0;
	int      stall_left = 0;
	bit      sender_gaps = 1'b0;
	bit      recv_stalls = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{FUNC_SOLVE, 4'd0,  4'd0,  16'd0,     4'd0},  1'b1, ANS_SRC},
		'{'{FUNC_SOLVE, 4'd15, 4'd15, 16'hFFFF,  4'd15}, 1'b1, ANS_MISS},
		'{'{FUNC_LOAD,  4'd15, 4'd0,  16'd0,     4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd0,  4'd15, 16'hFFFF,  4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd0,  4'd1,  16'd1,     4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd1,  4'd15, 16'd2,     4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd15, 4'd15, 16'hFFFF,  4'd15}, 1'b1, ANS_ACK},
		'{'{FUNC_SOLVE, 4'd0,  4'd0,  16'd0,     4'd15}, 1'b0, ANS_MISS},
		'{'{FUNC_SOLVE, 4'd0,  4'd0,  16'd0,     4'd15}, 1'b1, ANS_MISS},
		'{'{FUNC_LOAD,  4'd3,  4'd4,  16'hFFFF,  4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd2,  4'd3,  16'hFFFF,  4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd1,  4'd2,  16'hFFFF,  4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd0,  4'd1,  16'hFFFF,  4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_LOAD,  4'd4,  4'd0,  16'd7,     4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_SOLVE, 4'd0,  4'd0,  16'd0,     4'd4},  1'b0, ANS_MISS},
		'{'{FUNC_LOAD,  4'd0,  4'd9,  16'd0,     4'd0},  1'b1, ANS_ACK},
		'{'{FUNC_SOLVE, 4'd0,  4'd0,  16'd0,     4'd9},  1'b0, ANS_MISS},
		'{'{FUNC_SOLVE, 4'd0,  4'd0,  16'd0,     4'd0},  1'b1, ANS_SRC}
	};

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// node count as the block uses it: zero acts as one, large values clamp
	function automatic int nodes_active();
		if (cur_count == 0)
			return 1;
		if (cur_count > NODE_SLOTS)
			return NODE_SLOTS;
		return int'(cur_count);
	endfunction

	// answer for one transaction, updating the shadow table
	function automatic answer_t predict_answer(input edge_req_t it);
		answer_t                  ans;
		logic [DIST_OUT_BITS-1:0] hop_dist [NODE_SLOTS];
		bit                       seen [NODE_SLOTS];
		logic [DIST_OUT_BITS:0]   sum;
		int                       nodes;
		int                       a;
		int                       b;
		ans = ANS_MISS;
		if (it.func == FUNC_LOAD) begin
			ans.load_ack = 1'b1;
			if (tbl_len < EDGE_SLOTS) begin
				tbl_org[tbl_len]  = it.org;
				tbl_dst[tbl_len]  = it.dst;
				tbl_cost[tbl_len] = it.cost;
				tbl_len++;
			end else begin
				ans.dropped = 1'b1;
			end
			return ans;
		end
		nodes = nodes_active();
		for (int i = 0; i < NODE_SLOTS; i++) begin
			hop_dist[i] = '0;
			seen[i] = 1'b0;
		end
		if (int'(cur_source) < nodes)
			seen[cur_source] = 1'b1;
		// relax every stored edge in load order, nodes-1 rounds
		for (int round = 0; round + 1 < nodes; round++) begin
			for (int e = 0; e < tbl_len; e++) begin
				a = int'(tbl_org[e]);
				b = int'(tbl_dst[e]);
				if (a < nodes && b < nodes && seen[a]) begin
					sum = {1'b0, hop_dist[a]} + (DIST_OUT_BITS+1)'(tbl_cost[e]);
					if (sum > {1'b0, DIST_TOP})
						sum = {1'b0, DIST_TOP};
					if (!seen[b] || sum[DIST_OUT_BITS-1:0] < hop_dist[b]) begin
						hop_dist[b] = sum[DIST_OUT_BITS-1:0];
						seen[b] = 1'b1;
					end
				end
			end
		end
		if (int'(it.tgt) < nodes && seen[it.tgt]) begin
			ans.distance = hop_dist[it.tgt];
			ans.reached = 1'b1;
		end
		tbl_len = 0;
		return ans;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// one input transaction, with an optional gap ahead of it
	task automatic send_item(input edge_req_t it, input logic typed, input answer_t typed_ans);
		answer_t pred;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {4'd0, it.tgt, it.cost, it.dst, it.org};
		do @(posedge clk); while (!s_tready);
		pred = predict_answer(it);
		pending_answers.push_back(typed ? typed_ans : pred);
		sent_items++;
	endtask

	// hold off until every answer is in and the block has settled
	task automatic drain_answers();
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [NODE_BITS-1:0] src, input logic [4:0] cnt);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_SOURCE_NODE;
		cfg_wdata <= CFG_DATA_W'(src);
		@(posedge clk);
		cur_source = src;
		cfg_idx   <= REG_NODE_COUNT;
		cfg_wdata <= CFG_DATA_W'(cnt);
		@(posedge clk);
		cur_count = cnt;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [NODE_BITS-1:0] pick_node(input int nu);
		if ($urandom_range(0, 7) == 0)
			return NODE_BITS'($urandom_range(0, 15));
		return NODE_BITS'($urandom_range(0, nu - 1));
	endfunction

	function automatic logic [COST_BITS-1:0] pick_cost();
		case ($urandom_range(0, 3))
			0: return COST_BITS'($urandom_range(0, 65535));
			1: return COST_BITS'($urandom_range(0, 31));
			2: return '1;
			default: return COST_BITS'($urandom_range(0, 1000));
		endcase
	endfunction

	// receiver stalls in short bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// answer checker
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[23:0], m_tdata[24], m_tdata[25], m_tuser};
			if (pending_answers.size() == 0) begin
				note_mismatch("unexpected answer, distance", got.distance, 0);
			end else begin
				want = pending_answers.pop_front();
				if (got.distance !== want.distance)
					note_mismatch("distance", got.distance, want.distance);
				if (got.reached !== want.reached)
					note_mismatch("reached", got.reached, want.reached);
				if (got.dropped !== want.dropped)
					note_mismatch("load_dropped", got.dropped, want.dropped);
				if (got.load_ack !== want.load_ack)
					note_mismatch("is_load_ack", got.load_ack, want.load_ack);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [NODE_BITS-1:0] fixed_src [5];
		logic [4:0]           fixed_cnt [5];
		edge_req_t            it;
		int                   phase;
		int                   phase_stop;
		int                   kind;
		int                   loads;
		int                   nu;
		fixed_src = '{4'd15, 4'd0, 4'd3, 4'd15, 4'd9};
		fixed_cnt = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17};
		phase = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings
		sender_gaps <= 1'b1;
		recv_stalls <= 1'b1;
		for (int r = 0; r < DIR_ROWS; r++)
			send_item(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);

		// random phases, each under its own settings
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			drain_answers();
			if (phase < 5)
				set_config(fixed_src[phase], fixed_cnt[phase]);
			else begin
				case ($urandom_range(0, 9))
					0: kind = 0;
					1: kind = 1;
					2: kind = 16;
					3: kind = $urandom_range(17, 31);
					default: kind = $urandom_range(2, 15);
				endcase
				set_config(NODE_BITS'($urandom_range(0, 15)), 5'(kind));
			end
			phase++;
			sender_gaps <= (sent_items < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			recv_stalls <= (sent_items < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			nu = nodes_active();
			phase_stop = sent_items + 60 + $urandom_range(0, 40);
			while (sent_items < phase_stop && sent_items < RANDOM_ITEMS) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					// noise item with any field values
					it.func = 1'($urandom_range(0, 1));
					it.org  = NODE_BITS'($urandom_range(0, 15));
					it.dst  = NODE_BITS'($urandom_range(0, 15));
					it.cost = COST_BITS'($urandom_range(0, 65535));
					it.tgt  = NODE_BITS'($urandom_range(0, 15));
					send_item(it, 1'b0, ANS_MISS);
				end else begin
					// a graph load followed by a solve, overfilling the table now and then
					loads = (kind == 1) ? $urandom_range(30, 36) : $urandom_range(0, 10);
					for (int k = 0; k < loads; k++) begin
						it.func = FUNC_LOAD;
						it.org  = pick_node(nu);
						it.dst  = pick_node(nu);
						it.cost = pick_cost();
						it.tgt  = NODE_BITS'($urandom_range(0, 15));
						send_item(it, 1'b0, ANS_MISS);
					end
					it.func = FUNC_SOLVE;
					it.org  = NODE_BITS'($urandom_range(0, 15));
					it.dst  = NODE_BITS'($urandom_range(0, 15));
					it.cost = COST_BITS'($urandom_range(0, 65535));
					it.tgt  = pick_node(nu);
					send_item(it, 1'b0, ANS_MISS);
				end
			end
		end

		// final wait for outstanding answers
		drain_answers();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/bfsp_pkg.sv
rtl/bellman_ford_shortest_path.sv
tb/sv/bellman_ford_shortest_path_tb.sv
